/* rtl/cwmf_pkg.sv */
// ----------------------------------------------------------------------------
// cwmf_pkg
// shared types, constants and the microcode table of the clipped window
// median filter
// ----------------------------------------------------------------------------
package cwmf_pkg;

    localparam int DIM_W        = 13;   // holds any frame dimension up to 4096
    localparam int PIX_W        = 8;
    localparam int HIST_DEPTH   = 256;
    localparam int BIN_W        = 8;
    localparam int CNT_W        = 10;
    localparam int STEP_W       = 4;
    localparam int APB_ADDR_W   = 4;
    localparam int APB_DATA_W   = 32;
    localparam int REG_IDX_W    = 2;
    localparam int WIDTH_REG_W  = 9;
    localparam int HEIGHT_REG_W = 9;
    localparam int KERNEL_REG_W = 5;
    localparam int HALF_W       = 4;

    localparam int DEF_MAX_WIDTH         = 256;
    localparam int DEF_MAX_HEIGHT        = 256;
    localparam int DEF_MAX_WINDOW_PIXELS = 625;

    localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = WIDTH_REG_W'(256);
    localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = HEIGHT_REG_W'(256);
    localparam logic [KERNEL_REG_W-1:0] KERNEL_RESET = KERNEL_REG_W'(3);

    typedef logic [REG_IDX_W-1:0] reg_idx_t;
    localparam reg_idx_t REG_IMAGE_WIDTH  = 2'd0;
    localparam reg_idx_t REG_IMAGE_HEIGHT = 2'd1;
    localparam reg_idx_t REG_KERNEL_SIZE  = 2'd2;

    typedef logic op_t;
    localparam op_t OP_LOAD  = 1'b0;
    localparam op_t OP_QUERY = 1'b1;

    typedef logic [STEP_W-1:0] step_t;
    localparam step_t STEP_CLEAR  = 4'd0;
    localparam step_t STEP_IDLE   = 4'd1;
    localparam step_t STEP_SETUP  = 4'd2;
    localparam step_t STEP_WALK   = 4'd3;
    localparam step_t STEP_DRAIN0 = 4'd4;
    localparam step_t STEP_DRAIN1 = 4'd5;
    localparam step_t STEP_SCAN   = 4'd6;
    localparam step_t STEP_TAIL   = 4'd7;
    localparam step_t STEP_EMIT   = 4'd8;
    localparam step_t STEP_RET    = 4'd9;

    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_CLR,
        ACT_SETUP,
        ACT_WALK,
        ACT_SCAN,
        ACT_EMIT
    } act_t;

    typedef enum logic [2:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_CNT_MORE,
        COND_NO_QUERY,
        COND_ERR,
        COND_WIN_MORE,
        COND_OUT_FULL
    } cond_t;

    typedef struct packed {
        logic  in_rdy;
        act_t  act;
        cond_t cond;
        step_t target;
    } uword_t;

    // largest reach h with (2h+1)^2 inside the window budget
    function automatic int max_reach(int pixels);
        int h;
        h = 0;
        while ((2 * (h + 1) + 1) * (2 * (h + 1) + 1) <= pixels)
            h++;
        return h;
    endfunction

    // microcode: jump to target when cond holds, else fall through
    function automatic uword_t ucode(step_t s);
        uword_t w;
        case (s)
            STEP_CLEAR:  w = '{1'b0, ACT_CLR,   COND_CNT_MORE, STEP_CLEAR};
            STEP_IDLE:   w = '{1'b1, ACT_NONE,  COND_NO_QUERY, STEP_IDLE};
            STEP_SETUP:  w = '{1'b0, ACT_SETUP, COND_ERR,      STEP_EMIT};
            STEP_WALK:   w = '{1'b0, ACT_WALK,  COND_WIN_MORE, STEP_WALK};
            STEP_DRAIN0: w = '{1'b0, ACT_NONE,  COND_NEVER,    STEP_IDLE};
            STEP_DRAIN1: w = '{1'b0, ACT_NONE,  COND_NEVER,    STEP_IDLE};
            STEP_SCAN:   w = '{1'b0, ACT_SCAN,  COND_CNT_MORE, STEP_SCAN};
            STEP_TAIL:   w = '{1'b0, ACT_NONE,  COND_NEVER,    STEP_IDLE};
            STEP_EMIT:   w = '{1'b0, ACT_EMIT,  COND_OUT_FULL, STEP_EMIT};
            STEP_RET:    w = '{1'b0, ACT_NONE,  COND_ALWAYS,   STEP_IDLE};
            default:     w = '{1'b0, ACT_NONE,  COND_ALWAYS,   STEP_IDLE};
        endcase
        return w;
    endfunction

endpackage

/* rtl/cwmf_ram.sv */
// ----------------------------------------------------------------------------
// cwmf_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module cwmf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // read returns the old contents on a same-address write
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/clipped_window_median_filter_top.sv */
// ----------------------------------------------------------------------------
// clipped_window_median_filter_top
// frame store with median queries over a clipped square window
// ----------------------------------------------------------------------------
// A load (operation 0) writes one pixel into the frame memory and produces
// no result. A query (operation 1) returns the median of the window around
// (row, col), clipped at the configured image edges, for a window of at most
// 25x25 pixels: each window pixel goes through the frame memory read port
// into a 256-bin histogram, then a sweep of the histogram finds the rank and
// clears each bin behind it. After reset a clearing pass over all 256
// histogram bins runs before the first transaction is taken; configuration
// writes are taken at any time. A finished result is held in the output
// register while the next transaction comes in. Querying pixels that were
// never loaded gives an undefined median.
module clipped_window_median_filter_top
    import cwmf_pkg::*;
#(
    parameter int MAX_WIDTH         = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT        = DEF_MAX_HEIGHT,
    parameter int MAX_WINDOW_PIXELS = DEF_MAX_WINDOW_PIXELS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    // input channel
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  operation,
    input  logic [PIX_W-1:0]      row,
    input  logic [PIX_W-1:0]      col,
    input  logic [PIX_W-1:0]      pixel,
    // output channel
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [PIX_W-1:0]      median,
    output logic                  coord_error
);

    localparam int FR_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int FR_AW    = $clog2(FR_DEPTH);
    localparam int NW       = $clog2(MAX_WINDOW_PIXELS + 1);
    localparam int CUM_W    = NW + 1;
    localparam int LIM      = max_reach(MAX_WINDOW_PIXELS);

    // microcode sequencer
    uword_t uw;
    step_t  step_reg, step_next;
    logic   take;

    // configuration
    logic [WIDTH_REG_W-1:0]  width_reg, width_next;
    logic [HEIGHT_REG_W-1:0] height_reg, height_next;
    logic [KERNEL_REG_W-1:0] kernel_reg, kernel_next;
    logic                    cfg_wr;

    // query and window
    logic             in_acc;
    logic [PIX_W-1:0] q_row_reg, q_col_reg;
    logic [DIM_W-1:0] dim_w, dim_h, rowd, cold, halfd;
    logic [HALF_W-1:0] khalf, half;
    logic [DIM_W-1:0] r0, r1, c0, c1;
    logic             q_err;
    logic [DIM_W-1:0] wr_reg, wc_reg, r1_reg, c0_reg, c1_reg;
    logic             win_last;
    logic [NW-1:0]    n_reg;
    logic             err_reg;

    // frame memory
    logic             fr_we;
    logic [FR_AW-1:0] fr_waddr, fr_raddr;
    logic [PIX_W-1:0] fr_rdata;

    // histogram memory and its pipelines
    logic             h_we;
    logic [BIN_W-1:0] h_waddr, h_raddr;
    logic [CNT_W-1:0] h_wdata, h_rdata, h_cur, h_inc;
    logic             p1_reg, p2_reg, fw_valid_reg;
    logic [BIN_W-1:0] gc_reg, fw_addr_reg;
    logic [CNT_W-1:0] fw_data_reg;
    logic [BIN_W-1:0] cnt_reg, cnt_next;
    logic             sv_reg;
    logic [BIN_W-1:0] sb_reg;
    logic [CUM_W-1:0] cum_reg, cum_new;
    logic [NW-1:0]    rank;
    logic             hit;
    logic             found_reg, found_next;
    logic [BIN_W-1:0] med_reg;

    // output
    logic             out_valid_reg, out_valid_next, out_full;
    logic [PIX_W-1:0] median_reg;
    logic             coord_error_reg;

    assign uw = ucode(step_reg);

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        kernel_next = kernel_reg;
        if (cfg_wr)
        begin
            case (reg_idx_t'(paddr[APB_ADDR_W-1:2]))
                REG_IMAGE_WIDTH:  width_next  = pwdata[WIDTH_REG_W-1:0];
                REG_IMAGE_HEIGHT: height_next = pwdata[HEIGHT_REG_W-1:0];
                REG_KERNEL_SIZE:  kernel_next = pwdata[KERNEL_REG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx_t'(paddr[APB_ADDR_W-1:2]))
            REG_IMAGE_WIDTH:  prdata = APB_DATA_W'(width_reg);
            REG_IMAGE_HEIGHT: prdata = APB_DATA_W'(height_reg);
            REG_KERNEL_SIZE:  prdata = APB_DATA_W'(kernel_reg);
            default:          prdata = '0;
        endcase
    end

    // ---------------- input side ----------------
    assign in_ready = uw.in_rdy;
    assign in_acc   = in_valid & uw.in_rdy;

    assign fr_we = in_acc && (op_t'(operation) == OP_LOAD)
                   && (DIM_W'(row) < DIM_W'(MAX_HEIGHT))
                   && (DIM_W'(col) < DIM_W'(MAX_WIDTH));
    assign fr_waddr = FR_AW'(32'(row) * 32'(MAX_WIDTH) + 32'(col));
    assign fr_raddr = FR_AW'(32'(wr_reg) * 32'(MAX_WIDTH) + 32'(wc_reg));

    // ---------------- window bounds ----------------
    always_comb
    begin
        if (width_reg == '0)
            dim_w = DIM_W'(1);
        else if (DIM_W'(width_reg) > DIM_W'(MAX_WIDTH))
            dim_w = DIM_W'(MAX_WIDTH);
        else
            dim_w = DIM_W'(width_reg);

        if (height_reg == '0)
            dim_h = DIM_W'(1);
        else if (DIM_W'(height_reg) > DIM_W'(MAX_HEIGHT))
            dim_h = DIM_W'(MAX_HEIGHT);
        else
            dim_h = DIM_W'(height_reg);

        khalf = kernel_reg[KERNEL_REG_W-1:1];
        half  = (khalf > HALF_W'(LIM)) ? HALF_W'(LIM) : khalf;
        halfd = DIM_W'(half);
        rowd  = DIM_W'(q_row_reg);
        cold  = DIM_W'(q_col_reg);

        q_err = (rowd >= dim_h) || (cold >= dim_w);
        r0 = (rowd >= halfd) ? rowd - halfd : '0;
        c0 = (cold >= halfd) ? cold - halfd : '0;
        r1 = (rowd + halfd <= dim_h - DIM_W'(1)) ? rowd + halfd : dim_h - DIM_W'(1);
        c1 = (cold + halfd <= dim_w - DIM_W'(1)) ? cold + halfd : dim_w - DIM_W'(1);
    end

    assign win_last = (wr_reg == r1_reg) && (wc_reg == c1_reg);

    // ---------------- histogram datapath ----------------
    // one-deep bypass covers the bin written in the cycle before
    assign h_cur = (fw_valid_reg && (fw_addr_reg == gc_reg)) ? fw_data_reg : h_rdata;
    assign h_inc = h_cur + CNT_W'(1);

    always_comb
    begin
        h_we    = 1'b0;
        h_waddr = cnt_reg;
        h_wdata = '0;
        if (uw.act == ACT_CLR)
        begin
            h_we = 1'b1;
        end
        else if (p2_reg)
        begin
            h_we    = 1'b1;
            h_waddr = gc_reg;
            h_wdata = h_inc;
        end
        else if (sv_reg)
        begin
            h_we    = 1'b1;
            h_waddr = sb_reg;
        end
    end

    assign h_raddr = p1_reg ? fr_rdata : cnt_reg;

    assign rank    = n_reg >> 1;
    assign cum_new = cum_reg + CUM_W'(h_rdata);
    assign hit     = !found_reg && (cum_new > CUM_W'(rank));

    // ---------------- sequencer ----------------
    assign out_full = out_valid_reg & ~out_ready;

    always_comb
    begin
        case (uw.cond)
            COND_NEVER:    take = 1'b0;
            COND_ALWAYS:   take = 1'b1;
            COND_CNT_MORE: take = (cnt_reg != BIN_W'(HIST_DEPTH - 1));
            COND_NO_QUERY: take = !(in_acc && (op_t'(operation) == OP_QUERY));
            COND_ERR:      take = q_err;
            COND_WIN_MORE: take = !win_last;
            COND_OUT_FULL: take = out_full;
            default:       take = 1'b0;
        endcase
        step_next = take ? uw.target : step_reg + STEP_W'(1);
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if ((uw.act == ACT_CLR) || (uw.act == ACT_SCAN))
            cnt_next = cnt_reg + BIN_W'(1);

        found_next = found_reg;
        if (uw.act == ACT_SETUP)
            found_next = 1'b0;
        else if (sv_reg && hit)
            found_next = 1'b1;

        out_valid_next = out_valid_reg;
        if ((uw.act == ACT_EMIT) && !out_full)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= STEP_CLEAR;
            cnt_reg       <= '0;
            p1_reg        <= 1'b0;
            p2_reg        <= 1'b0;
            fw_valid_reg  <= 1'b0;
            sv_reg        <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            width_reg     <= WIDTH_RESET;
            height_reg    <= HEIGHT_RESET;
            kernel_reg    <= KERNEL_RESET;
        end
        else
        begin
            step_reg      <= step_next;
            cnt_reg       <= cnt_next;
            p1_reg        <= (uw.act == ACT_WALK);
            p2_reg        <= p1_reg;
            fw_valid_reg  <= p2_reg;
            sv_reg        <= (uw.act == ACT_SCAN);
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
            width_reg     <= width_next;
            height_reg    <= height_next;
            kernel_reg    <= kernel_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            q_row_reg <= row;
            q_col_reg <= col;
        end

        if (uw.act == ACT_SETUP)
        begin
            wr_reg  <= r0;
            wc_reg  <= c0;
            r1_reg  <= r1;
            c0_reg  <= c0;
            c1_reg  <= c1;
            n_reg   <= '0;
            cum_reg <= '0;
            err_reg <= q_err;
        end

        if (uw.act == ACT_WALK)
        begin
            n_reg <= n_reg + NW'(1);
            if (wc_reg == c1_reg)
            begin
                wc_reg <= c0_reg;
                wr_reg <= wr_reg + DIM_W'(1);
            end
            else
            begin
                wc_reg <= wc_reg + DIM_W'(1);
            end
        end

        if (p1_reg)
            gc_reg <= fr_rdata;

        if (p2_reg)
        begin
            fw_addr_reg <= gc_reg;
            fw_data_reg <= h_inc;
        end

        if (uw.act == ACT_SCAN)
            sb_reg <= cnt_reg;

        if (sv_reg)
        begin
            cum_reg <= cum_new;
            if (hit)
                med_reg <= sb_reg;
        end

        if ((uw.act == ACT_EMIT) && !out_full)
        begin
            coord_error_reg <= err_reg;
            if (err_reg)
                median_reg <= '0;
            else if (found_reg)
                median_reg <= med_reg;
            else
                median_reg <= PIX_W'(HIST_DEPTH - 1);
        end
    end

    assign out_valid   = out_valid_reg;
    assign median      = median_reg;
    assign coord_error = coord_error_reg;

    // ---------------- memories ----------------
    cwmf_ram #(
        .WIDTH (PIX_W),
        .DEPTH (FR_DEPTH)
    ) u_frame_ram (
        .clk   (clk),
        .we    (fr_we),
        .waddr (fr_waddr),
        .wdata (pixel),
        .raddr (fr_raddr),
        .rdata (fr_rdata)
    );

    cwmf_ram #(
        .WIDTH (CNT_W),
        .DEPTH (HIST_DEPTH)
    ) u_hist_ram (
        .clk   (clk),
        .we    (h_we),
        .waddr (h_waddr),
        .wdata (h_wdata),
        .raddr (h_raddr),
        .rdata (h_rdata)
    );

`ifndef SYNTH
    // increment writes and the sweep clear never overlap
    assert property (@(posedge clk) disable iff (!rst_n)
        !(p2_reg && sv_reg))
        else $error("histogram increment overlaps rank sweep");

    // walker stays inside the clipped window
    assert property (@(posedge clk) disable iff (!rst_n)
        (step_reg == STEP_WALK) |-> (wr_reg <= r1_reg) && (wc_reg <= c1_reg))
        else $error("window walker left the window");

    // window size within the pixel budget when the sweep starts
    assert property (@(posedge clk) disable iff (!rst_n)
        (step_reg == STEP_SCAN) |-> (32'(n_reg) <= MAX_WINDOW_PIXELS))
        else $error("window pixel count over budget");

    // an out-of-image query reports a zero median
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && coord_error) |-> (median == '0))
        else $error("coordinate error with non-zero median");
`endif

endmodule

/* tb/clipped_window_median_filter_top_test.sv */
// ----------------------------------------------------------------------------
// clipped_window_median_filter_top_test
// loads pixels and queries clipped-window medians through valid/ready, with
// register writes over apb between phases; every result is compared with a
// fixed expected value or a local frame copy and histogram rank search
// ----------------------------------------------------------------------------
module clipped_window_median_filter_top_test
    import cwmf_pkg::*;
();

    localparam int FRAME_W        = DEF_MAX_WIDTH;
    localparam int FRAME_H        = DEF_MAX_HEIGHT;
    localparam int SETTLE_CYCLES  = 900;
    localparam int PARK_CYCLES    = 3000;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int FILL_SIDE      = 13;
    localparam int NEAR_EDGE      = 16;
    localparam int NUM_PHASES     = 10;
    localparam int PHASE_ITEMS    = 48;
    localparam int PARK_PHASE     = 5;
    localparam int DRAIN_PHASE    = 3;

    typedef struct packed {
        logic [PIX_W-1:0] median;
        logic             coord_error;
    } median_result_t;

    typedef struct packed {
        logic             is_cfg;
        reg_idx_t         sel;
        logic [8:0]       value;
        op_t              op;
        logic [PIX_W-1:0] r;
        logic [PIX_W-1:0] c;
        logic [PIX_W-1:0] p;
        logic             typed;
        logic [PIX_W-1:0] med;
        logic             err;
    } probe_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  in_valid;
    logic                  in_ready;
    logic                  operation;
    logic [PIX_W-1:0]      row;
    logic [PIX_W-1:0]      col;
    logic [PIX_W-1:0]      pixel;
    logic                  out_valid;
    logic                  out_ready;
    logic [PIX_W-1:0]      median;
    logic                  coord_error;

    // local copy of the frame and the registers
    logic [PIX_W-1:0]      frame_mem [0:FRAME_W*FRAME_H-1];
    bit                    pixel_loaded [0:FRAME_W*FRAME_H-1];
    logic [8:0]            cfg_width;
    logic [8:0]            cfg_height;
    logic [4:0]            cfg_kernel;
    int                    reach_cap;

    median_result_t        pending_medians [$];
    probe_row_t            probe_table [$];
    int                    fail_count;
    int                    idle_cycles;
    bit                    sender_eager;
    bit                    receiver_eager;
    bit                    park_receiver;

    clipped_window_median_filter_top u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .operation   (operation),
        .row         (row),
        .col         (col),
        .pixel       (pixel),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .median      (median),
        .coord_error (coord_error)
    );

    always #2 clk = ~clk;

    function automatic int eff_dim(int v, int maxv);
        if (v < 1)
            return 1;
        if (v > maxv)
            return maxv;
        return v;
    endfunction

    // window bounds for a query; 0 when the position lies outside the image
    function automatic bit clip_window(input int qr, input int qc,
                                       output int r0, output int r1,
                                       output int c0, output int c1);
        int w;
        int h;
        int reach;
        w = eff_dim(cfg_width, FRAME_W);
        h = eff_dim(cfg_height, FRAME_H);
        r0 = 0;
        r1 = 0;
        c0 = 0;
        c1 = 0;
        if (qr >= h || qc >= w)
            return 1'b0;
        reach = cfg_kernel / 2;
        if (reach > reach_cap)
            reach = reach_cap;
        r0 = (qr >= reach) ? qr - reach : 0;
        r1 = (qr + reach <= h - 1) ? qr + reach : h - 1;
        c0 = (qc >= reach) ? qc - reach : 0;
        c1 = (qc + reach <= w - 1) ? qc + reach : w - 1;
        return 1'b1;
    endfunction

    function automatic bit window_loaded(int qr, int qc);
        int r0;
        int r1;
        int c0;
        int c1;
        if (!clip_window(qr, qc, r0, r1, c0, c1))
            return 1'b1;
        for (int r = r0; r <= r1; r++)
            for (int c = c0; c <= c1; c++)
                if (!pixel_loaded[r*FRAME_W + c])
                    return 1'b0;
        return 1'b1;
    endfunction

    // histogram of the window, then the first value whose running count
    // passes half the window size
    function automatic median_result_t predict_median(int qr, int qc);
        median_result_t res;
        int r0;
        int r1;
        int c0;
        int c1;
        int n;
        int rank;
        int cum;
        int picked;
        bit hit;
        logic [9:0] tally [0:255];
        res = '0;
        if (!clip_window(qr, qc, r0, r1, c0, c1))
        begin
            res.coord_error = 1'b1;
            return res;
        end
        foreach (tally[i])
            tally[i] = '0;
        n = 0;
        for (int r = r0; r <= r1; r++)
        begin
            for (int c = c0; c <= c1; c++)
            begin
                tally[frame_mem[r*FRAME_W + c]] += 10'd1;
                n++;
            end
        end
        rank = n / 2;
        cum = 0;
        picked = 255;
        hit = 1'b0;
        for (int v = 0; v < 256; v++)
        begin
            if (!hit)
            begin
                cum += tally[v];
                if (cum > rank)
                begin
                    picked = v;
                    hit = 1'b1;
                end
            end
        end
        res.median = PIX_W'(picked);
        return res;
    endfunction

    function automatic int draw_gap(bit eager);
        if (eager || $urandom_range(0, 3) == 0)
            return 0;
        return $urandom_range(0, 17);
    endfunction

    function automatic probe_row_t cfg_row(reg_idx_t sel, int value);
        probe_row_t x;
        x = '0;
        x.is_cfg = 1'b1;
        x.sel = sel;
        x.value = 9'(value);
        return x;
    endfunction

    function automatic probe_row_t load_row(int r, int c, int p);
        probe_row_t x;
        x = '0;
        x.op = OP_LOAD;
        x.r = PIX_W'(r);
        x.c = PIX_W'(c);
        x.p = PIX_W'(p);
        return x;
    endfunction

    function automatic probe_row_t query_row(int r, int c, int p);
        probe_row_t x;
        x = load_row(r, c, p);
        x.op = OP_QUERY;
        return x;
    endfunction

    function automatic probe_row_t known_row(int r, int c, int p, int med, bit err);
        probe_row_t x;
        x = query_row(r, c, p);
        x.typed = 1'b1;
        x.med = PIX_W'(med);
        x.err = err;
        return x;
    endfunction

    task automatic report_mismatch(string msg);
        $display("mismatch at %0t: %s", $time, msg);
        fail_count++;
    endtask

    task automatic check_result(logic [PIX_W-1:0] got_med, logic got_err);
        median_result_t want;
        if (pending_medians.size() == 0)
        begin
            report_mismatch($sformatf("result with nothing pending: median %0d flag %0b",
                                      got_med, got_err));
            return;
        end
        want = pending_medians.pop_front();
        if (got_err !== want.coord_error)
            report_mismatch($sformatf("coord_error %0b, wanted %0b",
                                      got_err, want.coord_error));
        if (got_med !== want.median)
            report_mismatch($sformatf("median %0d, wanted %0d", got_med, want.median));
    endtask

    // leaves in_valid high after the transaction; the next call or
    // settle_input decides at the following falling edge
    task automatic offer_pixel_op(op_t op_i, logic [PIX_W-1:0] r, logic [PIX_W-1:0] c,
                                  logic [PIX_W-1:0] p, logic typed,
                                  logic [PIX_W-1:0] med_i, logic err_i);
        int gap;
        median_result_t want;
        gap = draw_gap(sender_eager);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  <= 1'b1;
        operation <= op_i;
        row       <= r;
        col       <= c;
        pixel     <= p;
        do @(posedge clk); while (!in_ready);
        if (op_i == OP_LOAD)
        begin
            frame_mem[r*FRAME_W + c] = p;
            pixel_loaded[r*FRAME_W + c] = 1'b1;
        end
        else
        begin
            if (typed)
            begin
                want.median = med_i;
                want.coord_error = err_i;
            end
            else
                want = predict_median(r, c);
            pending_medians.push_back(want);
        end
    endtask

    task automatic settle_input();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    task automatic wait_for_results();
        while (pending_medians.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(reg_idx_t sel, logic [8:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'(sel) << 2;
        pwdata  <= APB_DATA_W'(value);
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        case (sel)
            REG_IMAGE_WIDTH:  cfg_width  = value;
            REG_IMAGE_HEIGHT: cfg_height = value;
            REG_KERNEL_SIZE:  cfg_kernel = value[4:0];
            default: ;
        endcase
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic send_random_load();
        if ($urandom_range(0, 9) < 7)
            offer_pixel_op(OP_LOAD, PIX_W'($urandom_range(0, NEAR_EDGE)),
                           PIX_W'($urandom_range(0, NEAR_EDGE)),
                           PIX_W'($urandom), 1'b0, '0, 1'b0);
        else
            offer_pixel_op(OP_LOAD, PIX_W'($urandom), PIX_W'($urandom),
                           PIX_W'($urandom), 1'b0, '0, 1'b0);
    endtask

    // watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("clipped_window_median_filter_top regression: fail");
                $finish;
            end
        end
    end

    // receiver: random stalls, and one long hold when asked
    initial
    begin
        int gap;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (park_receiver)
            begin
                out_ready <= 1'b0;
                park_receiver = 1'b0;
                repeat (PARK_CYCLES) @(negedge clk);
            end
            gap = draw_gap(receiver_eager);
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            check_result(median, coord_error);
        end
    end

    initial
    begin
        int w;
        int h;
        int k;
        int qr;
        int qc;
        bit found;
        clk            = 1'b0;
        rst_n          = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        in_valid       = 1'b0;
        operation      = OP_LOAD;
        row            = '0;
        col            = '0;
        pixel          = '0;
        fail_count     = 0;
        idle_cycles    = 0;
        sender_eager   = 1'b0;
        receiver_eager = 1'b0;
        park_receiver  = 1'b0;
        cfg_width      = 9'd256;
        cfg_height     = 9'd256;
        cfg_kernel     = 5'd3;
        reach_cap      = 0;
        while ((2*reach_cap + 3) * (2*reach_cap + 3) <= DEF_MAX_WINDOW_PIXELS)
            reach_cap++;
        foreach (frame_mem[i])
        begin
            frame_mem[i] = '0;
            pixel_loaded[i] = 1'b0;
        end

        probe_table = '{
            // even windows take the upper median
            load_row(0, 0, 0), load_row(0, 1, 255), load_row(1, 0, 255), load_row(1, 1, 255),
            known_row(0, 0, 0, 255, 1'b0),
            load_row(255, 255, 0), load_row(254, 255, 0), load_row(255, 254, 0),
            load_row(254, 254, 255),
            known_row(255, 255, 255, 0, 1'b0),
            cfg_row(REG_KERNEL_SIZE, 1),
            known_row(1, 1, 0, 255, 1'b0),
            // zero width acts as one column
            cfg_row(REG_IMAGE_WIDTH, 0),
            known_row(0, 1, 0, 0, 1'b1),
            known_row(0, 0, 0, 0, 1'b0),
            // oversize width saturates, zero height acts as one row
            cfg_row(REG_IMAGE_WIDTH, 511), cfg_row(REG_IMAGE_HEIGHT, 0),
            known_row(1, 0, 0, 0, 1'b1),
            load_row(0, 255, 128),
            known_row(0, 255, 0, 128, 1'b0),
            // kernel beyond the window budget, clipped to a 2x2 image
            cfg_row(REG_IMAGE_WIDTH, 2), cfg_row(REG_IMAGE_HEIGHT, 2),
            cfg_row(REG_KERNEL_SIZE, 31),
            known_row(0, 0, 0, 255, 1'b0),
            known_row(2, 0, 0, 0, 1'b1),
            known_row(0, 2, 0, 0, 1'b1),
            load_row(5, 5, 77),
            cfg_row(REG_KERNEL_SIZE, 0),
            known_row(1, 0, 0, 255, 1'b0),
            cfg_row(REG_IMAGE_WIDTH, 256), cfg_row(REG_IMAGE_HEIGHT, 256),
            cfg_row(REG_KERNEL_SIZE, 2),
            load_row(0, 2, 9), load_row(1, 2, 9),
            query_row(0, 1, 0)
        };

        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        foreach (probe_table[i])
        begin
            if (probe_table[i].is_cfg)
            begin
                settle_input();
                wait_for_results();
                cfg_write(probe_table[i].sel, probe_table[i].value);
            end
            else
                offer_pixel_op(probe_table[i].op, probe_table[i].r, probe_table[i].c,
                               probe_table[i].p, probe_table[i].typed,
                               probe_table[i].med, probe_table[i].err);
        end

        // fill the top-left corner so that most windows near the origin are legal
        for (int r = 0; r < FILL_SIDE; r++)
            for (int c = 0; c < FILL_SIDE; c++)
                offer_pixel_op(OP_LOAD, PIX_W'(r), PIX_W'(c), PIX_W'($urandom),
                               1'b0, '0, 1'b0);

        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            case (phase)
                0:       begin w = 13;  h = 13;  k = 3;  end
                1:       begin w = 1;   h = 256; k = 25; end
                2:       begin w = 256; h = 1;   k = 0;  end
                3:       begin w = 511; h = 0;   k = 31; end
                4:       begin w = 256; h = 256; k = 26; end
                default:
                begin
                    w = $urandom_range(1, 16);
                    h = $urandom_range(1, 16);
                    k = $urandom_range(0, 31);
                end
            endcase
            settle_input();
            wait_for_results();
            cfg_write(REG_IMAGE_WIDTH, 9'(w));
            cfg_write(REG_IMAGE_HEIGHT, 9'(h));
            cfg_write(REG_KERNEL_SIZE, 9'(k));
            sender_eager   = (phase % 3 == 1);
            receiver_eager = (phase % 4 == 2);
            // hold the output off while queries keep coming
            if (phase == PARK_PHASE)
                park_receiver = 1'b1;

            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (phase == DRAIN_PHASE && i == PHASE_ITEMS / 2)
                begin
                    settle_input();
                    wait_for_results();
                end
                if ($urandom_range(0, 99) < 35)
                    send_random_load();
                else
                begin
                    found = 1'b0;
                    qr = 0;
                    qc = 0;
                    for (int t = 0; t < 8 && !found; t++)
                    begin
                        if ($urandom_range(0, 4) == 0)
                        begin
                            qr = $urandom_range(0, 255);
                            qc = $urandom_range(0, 255);
                        end
                        else
                        begin
                            qr = $urandom_range(0, NEAR_EDGE);
                            qc = $urandom_range(0, NEAR_EDGE);
                        end
                        found = window_loaded(qr, qc);
                    end
                    if (found)
                        offer_pixel_op(OP_QUERY, PIX_W'(qr), PIX_W'(qc), PIX_W'($urandom),
                                       1'b0, '0, 1'b0);
                    else
                        send_random_load();
                end
            end
        end

        settle_input();
        wait_for_results();
        if (fail_count == 0)
            $display("clipped_window_median_filter_top regression: pass");
        else
            $display("clipped_window_median_filter_top regression: fail");
        $finish;
    end

endmodule
